// ----- hw/rtl/cbre_pkg.sv -----
// ---------------------------------------------------------------------------
// cbre_pkg
// Shared codes, bank map and controller/datapath handshake types for the
// CPU bus ROM/RAM emulator.
// ---------------------------------------------------------------------------
package cbre_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [2:0] STG_A1 = 3'd0;
    localparam logic [2:0] STG_A2 = 3'd1;
    localparam logic [2:0] STG_A3 = 3'd2;
    localparam logic [2:0] STG_M1 = 3'd3;
    localparam logic [2:0] STG_M2 = 3'd4;
    localparam logic [2:0] STG_X1 = 3'd5;
    localparam logic [2:0] STG_X2 = 3'd6;
    localparam logic [2:0] STG_X3 = 3'd7;

    localparam logic [1:0] MODE_STALE     = 2'd0;
    localparam logic [1:0] MODE_RESETTING = 2'd1;
    localparam logic [1:0] MODE_RUNNING   = 2'd2;
    localparam logic [1:0] MODE_FINISHED  = 2'd3;

    localparam logic [1:0] BUS_LEAVE   = 2'd0;
    localparam logic [1:0] BUS_DRIVE   = 2'd1;
    localparam logic [1:0] BUS_RELEASE = 2'd2;

    localparam logic [7:0] OP_HLT = 8'h01;
    localparam logic [7:0] OP_WRM = 8'hE0;
    localparam logic [7:0] OP_WMP = 8'hE1;
    localparam logic [7:0] OP_WR0 = 8'hE4;
    localparam logic [7:0] OP_SBM = 8'hE8;
    localparam logic [7:0] OP_RDM = 8'hE9;
    localparam logic [7:0] OP_ADM = 8'hEB;
    localparam logic [7:0] OP_RD0 = 8'hEC;

    localparam logic [1:0]  ROM_SEL_UPPER = 2'd2;
    localparam logic [12:0] ROM_UPPER_OFS = 13'h1000;

    localparam int BANK_SLOTS = 8;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    localparam logic [2:0] BANK_MAP [16] = '{
        3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd4, 3'd0,
        3'd3, 3'd0, 3'd5, 3'd0, 3'd6, 3'd0, 3'd7, 3'd0
    };

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } cbre_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } cbre_stat_t;

    function automatic logic [2:0] map_bank(input logic [3:0] sel, input logic [3:0] banks);
        logic [2:0] b;
        b = BANK_MAP[sel];
        if ({1'b0, b} >= banks) begin
            b = 3'd0;
        end
        return b;
    endfunction

endpackage

// ----- hw/rtl/cbre_ram.sv -----
// ---------------------------------------------------------------------------
// cbre_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module cbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cbre_ctrl.sv -----
// ---------------------------------------------------------------------------
// cbre_ctrl
// Sequencer: RAM clearing pass, beat accept, memory read, commit.
// ---------------------------------------------------------------------------
module cbre_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cbre_pkg::cbre_stat_t stat,
    output cbre_pkg::cbre_cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                state_next = S_FINAL;
            end
            S_FINAL: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

`ifndef ASSERT_OFF
    a_commit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("commit without free output register");
    a_read_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == S_READ))
        else $error("accepted beat did not advance to read");
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !cmd.capture && !cmd.commit)
        else $error("beat handled during clearing pass");
`endif

endmodule

// ----- hw/rtl/cbre_dp.sv -----
// ---------------------------------------------------------------------------
// cbre_dp
// Bus cycle datapath: stage tracking, address assembly, ROM/RAM access,
// bank selection and the result register.
// ---------------------------------------------------------------------------
module cbre_dp #(
    parameter int ROM_WORDS = 8192,
    parameter int RAM_BANKS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cbre_pkg::cbre_cmd_t                  cmd,
    output cbre_pkg::cbre_stat_t                 stat,
    input  logic [cbre_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cbre_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [1:0]                           m_tuser
);

    localparam int ROM_AW      = $clog2(ROM_WORDS);
    localparam int MAIN_DEPTH  = RAM_BANKS * 256;
    localparam int MAIN_AW     = $clog2(MAIN_DEPTH);
    localparam int STAT_DEPTH  = RAM_BANKS * 64;
    localparam int STAT_AW     = $clog2(STAT_DEPTH);
    localparam logic [13:0] ROM_LIM = 14'(ROM_WORDS);
    localparam logic [3:0]  BANKS_W = 4'(RAM_BANKS);

    // captured beat
    logic [1:0]  act_reg;
    logic        sync_reg;
    logic [3:0]  bus_reg;
    logic [1:0]  romsel_reg;
    logic [3:0]  ramsel_reg;
    logic [12:0] laddr_reg;
    logic [7:0]  lbyte_reg;

    // emulator state
    logic [2:0]  stage_reg,  stage_next;
    logic [12:0] fetch_reg,  fetch_next;
    logic [7:0]  opc_reg,    opc_next;
    logic        srcp_reg,   srcp_next;
    logic [3:0]  srcr_reg,   srcr_next;
    logic        io_reg,     io_next;
    logic [2:0]  bank_reg,   bank_next;
    logic [1:0]  mode_reg,   mode_next;
    logic        pin_reg,    pin_next;
    logic [3:0]  bsr_reg [cbre_pkg::BANK_SLOTS];
    logic [3:0]  bsc_reg [cbre_pkg::BANK_SLOTS];
    logic        bs_we;

    logic [MAIN_AW-1:0] clr_cnt_reg;

    logic                         m_valid_reg;
    logic [cbre_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [1:0]                   m_user_reg;

    logic [1:0] op_next;
    logic [3:0] val_next;
    logic       pv_next;
    logic [3:0] pval_next;
    logic       main_wr;
    logic       stat_wr;

    logic [12:0] rom_sum;
    logic [12:0] rom_full;
    logic [13:0] rom_wrap;
    logic        load_ok;
    logic [7:0]  rom_rdata;
    logic [10:0] main_full;
    logic [8:0]  stat_full;
    logic [3:0]  main_rdata;
    logic [3:0]  stat_rdata;
    logic        active;

    logic               main_we;
    logic [MAIN_AW-1:0] main_waddr;
    logic [3:0]         main_wdata;
    logic               stat_we;
    logic [STAT_AW-1:0] stat_waddr;
    logic [3:0]         stat_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg    <= s_tuser;
            sync_reg   <= s_tdata[0];
            bus_reg    <= s_tdata[4:1];
            romsel_reg <= s_tdata[6:5];
            ramsel_reg <= s_tdata[10:7];
            laddr_reg  <= s_tdata[23:11];
            lbyte_reg  <= s_tdata[31:24];
        end
    end

    assign rom_sum  = fetch_reg + ((romsel_reg == cbre_pkg::ROM_SEL_UPPER) ?
                                   cbre_pkg::ROM_UPPER_OFS : 13'd0);
    assign rom_full = rom_sum | {1'b0, bus_reg, 8'd0};
    assign rom_wrap = ({1'b0, rom_full} >= ROM_LIM) ? ({1'b0, rom_full} - ROM_LIM)
                                                    : {1'b0, rom_full};
    assign load_ok  = ({1'b0, laddr_reg} < ROM_LIM);

    assign main_full = {bank_reg, bsr_reg[bank_reg], bsc_reg[bank_reg]};
    assign stat_full = {bank_reg, bsr_reg[bank_reg], opc_reg[1:0]};
    assign active    = (act_reg == cbre_pkg::ACT_TICK) &&
                       ((mode_reg == cbre_pkg::MODE_RESETTING) ||
                        (mode_reg == cbre_pkg::MODE_RUNNING));

    always_comb begin
        stage_next = stage_reg;
        fetch_next = fetch_reg;
        opc_next   = opc_reg;
        srcp_next  = srcp_reg;
        srcr_next  = srcr_reg;
        io_next    = io_reg;
        bank_next  = bank_reg;
        mode_next  = mode_reg;
        pin_next   = pin_reg;
        bs_we      = 1'b0;
        op_next    = cbre_pkg::BUS_LEAVE;
        val_next   = 4'd0;
        pv_next    = 1'b0;
        pval_next  = 4'd0;
        main_wr    = 1'b0;
        stat_wr    = 1'b0;
        if (act_reg == cbre_pkg::ACT_START) begin
            mode_next = cbre_pkg::MODE_RESETTING;
        end else if (active && sync_reg) begin
            bs_we      = srcp_reg;
            op_next    = cbre_pkg::BUS_RELEASE;
            stage_next = cbre_pkg::STG_A1;
        end else if (active) begin
            case (stage_reg)
                cbre_pkg::STG_A1: begin
                    stage_next = cbre_pkg::STG_A2;
                    fetch_next = {9'd0, bus_reg};
                end
                cbre_pkg::STG_A2: begin
                    stage_next = cbre_pkg::STG_A3;
                    fetch_next = fetch_reg | {5'd0, bus_reg, 4'd0};
                end
                cbre_pkg::STG_A3: begin
                    fetch_next = rom_full;
                    opc_next   = rom_rdata;
                    stage_next = cbre_pkg::STG_M1;
                    if (mode_reg != cbre_pkg::MODE_RESETTING) begin
                        op_next  = cbre_pkg::BUS_DRIVE;
                        val_next = rom_rdata[7:4];
                    end
                end
                cbre_pkg::STG_M1: begin
                    if (ramsel_reg != 4'd0 && opc_reg == cbre_pkg::OP_HLT) begin
                        pin_next  = 1'b0;
                        mode_next = cbre_pkg::MODE_FINISHED;
                    end else begin
                        stage_next = cbre_pkg::STG_M2;
                        if (mode_reg != cbre_pkg::MODE_RESETTING) begin
                            op_next  = cbre_pkg::BUS_DRIVE;
                            val_next = opc_reg[3:0];
                        end
                    end
                end
                cbre_pkg::STG_M2: begin
                    if (ramsel_reg != 4'd0) begin
                        bank_next = cbre_pkg::map_bank(ramsel_reg, BANKS_W);
                        io_next   = 1'b1;
                    end else begin
                        io_next = 1'b0;
                    end
                    stage_next = cbre_pkg::STG_X1;
                end
                cbre_pkg::STG_X1: begin
                    op_next    = cbre_pkg::BUS_RELEASE;
                    stage_next = cbre_pkg::STG_X2;
                    if (io_reg) begin
                        if (opc_reg == cbre_pkg::OP_SBM || opc_reg == cbre_pkg::OP_RDM ||
                            opc_reg == cbre_pkg::OP_ADM) begin
                            op_next  = cbre_pkg::BUS_DRIVE;
                            val_next = main_rdata;
                        end else if (opc_reg[7:2] == cbre_pkg::OP_RD0[7:2]) begin
                            op_next  = cbre_pkg::BUS_DRIVE;
                            val_next = stat_rdata;
                        end
                    end
                end
                cbre_pkg::STG_X2: begin
                    stage_next = cbre_pkg::STG_X3;
                    if (mode_reg == cbre_pkg::MODE_RESETTING) begin
                        pin_next  = 1'b1;
                        mode_next = cbre_pkg::MODE_RUNNING;
                    end else if (ramsel_reg != 4'd0) begin
                        srcr_next = bus_reg;
                        bank_next = cbre_pkg::map_bank(ramsel_reg, BANKS_W);
                        srcp_next = 1'b1;
                    end else begin
                        if (io_reg) begin
                            if (opc_reg == cbre_pkg::OP_WRM) begin
                                main_wr = 1'b1;
                            end else if (opc_reg[7:2] == cbre_pkg::OP_WR0[7:2]) begin
                                stat_wr = 1'b1;
                            end else if (opc_reg == cbre_pkg::OP_WMP) begin
                                pv_next   = 1'b1;
                                pval_next = bus_reg;
                            end
                        end
                        srcp_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= cbre_pkg::STG_X3;
            fetch_reg <= 13'd0;
            opc_reg   <= 8'd0;
            srcp_reg  <= 1'b0;
            srcr_reg  <= 4'd0;
            io_reg    <= 1'b0;
            bank_reg  <= 3'd0;
            mode_reg  <= cbre_pkg::MODE_STALE;
            pin_reg   <= 1'b0;
            for (int i = 0; i < cbre_pkg::BANK_SLOTS; i++) begin
                bsr_reg[i] <= 4'd0;
                bsc_reg[i] <= 4'd0;
            end
        end else if (cmd.commit) begin
            stage_reg <= stage_next;
            fetch_reg <= fetch_next;
            opc_reg   <= opc_next;
            srcp_reg  <= srcp_next;
            srcr_reg  <= srcr_next;
            io_reg    <= io_next;
            bank_reg  <= bank_next;
            mode_reg  <= mode_next;
            pin_reg   <= pin_next;
            if (bs_we) begin
                bsr_reg[bank_reg] <= srcr_reg;
                bsc_reg[bank_reg] <= bus_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == MAIN_AW'(MAIN_DEPTH - 1));
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign main_we    = cmd.clear_step || (cmd.commit && main_wr);
    assign main_waddr = cmd.clear_step ? clr_cnt_reg : main_full[MAIN_AW-1:0];
    assign main_wdata = cmd.clear_step ? 4'd0 : bus_reg;
    assign stat_we    = (cmd.clear_step && (clr_cnt_reg < MAIN_AW'(STAT_DEPTH))) ||
                        (cmd.commit && stat_wr);
    assign stat_waddr = cmd.clear_step ? clr_cnt_reg[STAT_AW-1:0] : stat_full[STAT_AW-1:0];
    assign stat_wdata = cmd.clear_step ? 4'd0 : bus_reg;

    cbre_ram #(.WIDTH(8), .DEPTH(ROM_WORDS)) u_rom (
        .aclk  (aclk),
        .we    (cmd.commit && (act_reg == cbre_pkg::ACT_LOAD) && load_ok),
        .waddr (laddr_reg[ROM_AW-1:0]),
        .wdata (lbyte_reg),
        .raddr (rom_wrap[ROM_AW-1:0]),
        .rdata (rom_rdata)
    );

    cbre_ram #(.WIDTH(4), .DEPTH(MAIN_DEPTH)) u_main (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_full[MAIN_AW-1:0]),
        .rdata (main_rdata)
    );

    cbre_ram #(.WIDTH(4), .DEPTH(STAT_DEPTH)) u_status (
        .aclk  (aclk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .raddr (stat_full[STAT_AW-1:0]),
        .rdata (stat_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= {4'd0, pval_next, pv_next, pin_next, mode_next, val_next};
            m_user_reg <= op_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed beat not presented");
    a_port_write_in_x2: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && pv_next |-> stage_reg == cbre_pkg::STG_X2 && io_reg)
        else $error("port write outside X2");
    a_pin_rise_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pin_reg) |-> mode_reg == cbre_pkg::MODE_RUNNING)
        else $error("reset pin released outside running mode");
    a_halt_leaves_bus: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && mode_next == cbre_pkg::MODE_FINISHED &&
        mode_reg != cbre_pkg::MODE_FINISHED |-> op_next == cbre_pkg::BUS_LEAVE && !pin_next)
        else $error("halt drove the bus or kept the CPU running");
`endif

endmodule

// ----- hw/rtl/cpu_bus_rom_ram_emulator.sv -----
// ---------------------------------------------------------------------------
// cpu_bus_rom_ram_emulator
// Memory side of a 4-bit CPU's eight-phase bus cycle: ROM, RAM and port.
//
//   channel  dir  handshake          tdata             tuser
//   s_       in   s_tvalid/s_tready  32 bit beat       action
//   m_       out  m_tvalid/m_tready  16 bit result     bus_op
//
// Each beat passes through accept, memory read and commit into the result
// register; commit waits while the result register is full and not taken.
// After reset a clearing pass zeroes main RAM (RAM_BANKS*256 words, 2048 by
// default) and status RAM with s_tready low.
// The next beat is accepted while a result still waits on the m_ side.
// ---------------------------------------------------------------------------
module cpu_bus_rom_ram_emulator #(
    parameter int ROM_WORDS = 8192,
    parameter int RAM_BANKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sync_line[0], bus_in[4:1], rom_select[6:5], ram_select[10:7],
    // load_addr[23:11], load_byte[31:24]
    input  logic [31:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_value[3:0], run_state[5:4], cpu_reset_release[6],
    // port_write_valid[7], port_write_value[11:8], zero[15:12]
    output logic [15:0] m_tdata,
    // bus_op[1:0]
    output logic [1:0]  m_tuser
);

    cbre_pkg::cbre_cmd_t  cmd;
    cbre_pkg::cbre_stat_t stat;

    cbre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cbre_dp #(
        .ROM_WORDS (ROM_WORDS),
        .RAM_BANKS (RAM_BANKS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
